>>> design/dop_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dop_pkg: shared constants and types of the dhcp offer parser
// Byte offsets of the message header and option area, option codes, verdict
// codes, and the queue entry that the front end hands to the option walker.
// ----------------------------------------------------------------------------
package dop_pkg;

  localparam int OFFSET_W = 11;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

  // message layout
  localparam int XID_FIRST = 4;
  localparam int YI_FIRST  = 16;
  localparam int OPT_START = 240;
  localparam int OPT_AREA  = 312;
  localparam int MIN_LEN   = 240;

  // the walker trails the incoming byte by four, so an option value is in view
  localparam int WALK_LAG    = 4;
  localparam int DRAIN_STEPS = WALK_LAG + 1;
  localparam int DRAIN_W     = $clog2(DRAIN_STEPS);
  localparam int WALK_FIRST  = OPT_START + WALK_LAG;
  localparam int WALK_STOP   = WALK_FIRST + OPT_AREA;

  localparam logic [31:0] XID_RESET = 32'h1234_5678;
  localparam logic [31:0] DEF_MASK  = 32'h00FF_FFFF;
  localparam logic [31:0] DEF_DNS   = 32'h0808_0808;

  // option codes
  localparam logic [7:0] OPT_PAD      = 8'd0;
  localparam logic [7:0] OPT_MASK     = 8'd1;
  localparam logic [7:0] OPT_ROUTER   = 8'd3;
  localparam logic [7:0] OPT_DNS      = 8'd6;
  localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
  localparam logic [7:0] OPT_SERVER   = 8'd54;
  localparam logic [7:0] OPT_END      = 8'd255;
  localparam logic [7:0] MSG_OFFER    = 8'd2;

  // verdict codes
  localparam logic [1:0] VERDICT_OFFER     = 2'd0;
  localparam logic [1:0] VERDICT_SHORT     = 2'd1;
  localparam logic [1:0] VERDICT_MISMATCH  = 2'd2;
  localparam logic [1:0] VERDICT_NOT_OFFER = 2'd3;

  // queue between front end and walker
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // result: verdict, offered_ip, netmask, gateway, dns_server, server_id, pad
  localparam int RES_W = 2 + 5 * 32;
  localparam int OUT_W = ((RES_W + 7) / 8) * 8;

  typedef struct packed {
    logic                   xid_we;
    logic [1:0]             xid_lane;
    logic                   yi_we;
    logic [1:0]             yi_lane;
    logic                   walk_on;
    logic                   area_end;
    logic                   short_msg;
    logic [DRAIN_STEPS-1:0] drain_act;
    logic [DRAIN_STEPS-1:0] drain_end;
  } byte_class_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    byte_class_t cls;
  } q_entry_t;

endpackage

>>> design/dhcp_offer_option_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhcp_offer_option_parser: DHCP offer checker and option extractor
// Takes a DHCP message byte by byte and gives one verdict per message with
// the offered address and network settings.
// ----------------------------------------------------------------------------
// Bytes are taken at one per cycle, while the queue has room, into an 8-entry
// queue; the option walker behind it handles one byte per cycle unless it is
// draining or a final byte waits for the output register, and trails the input
// by four bytes so each option value is in view when its length byte is walked.
// After the final byte of a message of 240 bytes or more whose transaction id
// matches, the walker runs out that look-ahead with zero bytes before it gives
// the result; shorter or mismatched messages finish on their final byte. The
// result is registered and appears in the cycle after the walker finishes the
// final byte (or the drain). The expected id is written through the cfg channel;
// the user must write it only while no message is in flight (not enforced here).
module dhcp_offer_option_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [31:0]               cfg_data,       // expected_xid
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // data_byte
  input  logic                      s_axis_tlast,   // last_byte
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [dop_pkg::OUT_W-1:0] m_axis_tdata    // verdict[1:0], yiaddr, netmask,
                                                     // gateway, dns_server, server_id
);
  import dop_pkg::*;

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  q_entry_t q_in;
  q_entry_t q_head;

  dop_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_push        (q_push),
    .q_entry       (q_in),
    .q_full        (q_full)
  );

  dop_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  dop_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .head          (q_head),
    .empty         (q_empty),
    .pop           (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

>>> design/dop_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dop_front: byte intake and classification
// Counts the byte offset within the message and tags each byte with what
// the walker must do with it, then pushes it into the queue.
// ----------------------------------------------------------------------------
module dop_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // data_byte
  input  logic              s_axis_tlast,   // last_byte
  output logic              q_push,
  output dop_pkg::q_entry_t q_entry,
  input  logic              q_full
);
  import dop_pkg::*;

  logic [OFFSET_W-1:0] offset;
  logic [OFFSET_W-1:0] offset_next;
  logic                accept;
  byte_class_t         cls;

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign q_push        = accept;

  always_comb begin
    cls           = '0;
    cls.xid_we    = (offset >= OFFSET_W'(XID_FIRST)) && (offset <= OFFSET_W'(XID_FIRST + 3));
    cls.xid_lane  = 2'(offset - OFFSET_W'(XID_FIRST));
    // address is big-endian: first byte lands in the top lane
    cls.yi_we     = (offset >= OFFSET_W'(YI_FIRST)) && (offset <= OFFSET_W'(YI_FIRST + 3));
    cls.yi_lane   = 2'(OFFSET_W'(YI_FIRST + 3) - offset);
    cls.walk_on   = offset >= OFFSET_W'(WALK_FIRST);
    cls.area_end  = offset >= OFFSET_W'(WALK_STOP);
    cls.short_msg = offset < OFFSET_W'(MIN_LEN - 1);
    // positions the walker still visits after the final byte
    for (int k = 0; k < DRAIN_STEPS; k++) begin
      cls.drain_act[k] = ({1'b0, offset} + (OFFSET_W+1)'(k + 1)) >= (OFFSET_W+1)'(WALK_FIRST);
      cls.drain_end[k] = ({1'b0, offset} + (OFFSET_W+1)'(k + 1)) >= (OFFSET_W+1)'(WALK_STOP);
    end
  end

  assign q_entry = '{data: s_axis_tdata, last: s_axis_tlast, cls: cls};

  always_comb begin
    offset_next = offset;
    if (accept) begin
      if (s_axis_tlast) begin
        offset_next = '0;
      end else if (offset != OFFSET_MAX) begin
        offset_next = offset + OFFSET_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
    end else begin
      offset <= offset_next;
    end
  end

  a_offset_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && s_axis_tlast) |=> (offset == '0))
    else $error("byte offset not restarted after final byte");

endmodule

>>> design/dop_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dop_fifo: short queue between front end and walker
// Register-based first-in first-out buffer; the head entry is always visible.
// ----------------------------------------------------------------------------
module dop_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dop_pkg::q_entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output dop_pkg::q_entry_t head,
  output logic              empty
);
  import dop_pkg::*;

  q_entry_t           slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;

  assign full  = count == FIFO_CW'(FIFO_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + FIFO_AW'(1);
      end
      if (push && !pop) begin
        count <= count + FIFO_CW'(1);
      end else if (pop && !push) begin
        count <= count - FIFO_CW'(1);
      end
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue popped while empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue pushed while full");

endmodule

>>> design/dop_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dop_back: option walker and result stage
// Captures id and offered address, walks the option list one byte per cycle
// when not stalled, drains look-ahead after the last byte, registers result.
// ----------------------------------------------------------------------------
module dop_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [31:0]               cfg_data,     // expected_xid
  input  dop_pkg::q_entry_t         head,
  input  logic                      empty,
  output logic                      pop,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [dop_pkg::OUT_W-1:0] m_axis_tdata  // verdict, yiaddr, netmask,
                                                   // gateway, dns_server, server_id
);
  import dop_pkg::*;

  localparam logic [1:0] PH_CODE = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_SKIP = 2'd2;
  localparam logic [DRAIN_W-1:0] DRAIN_LAST = DRAIN_W'(DRAIN_STEPS - 1);

  typedef struct packed {
    logic [1:0]      phase;
    logic [7:0]      skip;
    logic [7:0]      code;
    logic [3:0][7:0] la;     // la[0] is the byte under the walker
    logic            done;
    logic [7:0]      kind;
    logic [31:0]     mask;
    logic [31:0]     router;
    logic [31:0]     dns;
    logic [31:0]     sid;
  } walk_t;

  function automatic walk_t walk_step(walk_t s, logic [7:0] incoming, logic active,
                                      logic area_end);
    walk_t       n;
    logic [7:0]  b;
    logic [31:0] v;
    n = s;
    b = s.la[0];
    v = {s.la[1], s.la[2], s.la[3], incoming};
    if (active && !s.done) begin
      unique case (s.phase)
        PH_LEN: begin
          case (s.code)
            OPT_MSG_TYPE: n.kind   = s.la[1];
            OPT_SERVER:   n.sid    = v;
            OPT_MASK:     n.mask   = v;
            OPT_ROUTER:   n.router = v;
            OPT_DNS:      n.dns    = v;
            default:      ;
          endcase
          n.skip  = b;
          n.phase = (b != 8'd0) ? PH_SKIP : PH_CODE;
        end
        PH_SKIP: begin
          if (s.skip <= 8'd1) begin
            n.skip  = '0;
            n.phase = PH_CODE;
          end else begin
            n.skip = s.skip - 8'd1;
          end
        end
        default: begin
          if (area_end || b == OPT_END) begin
            n.done = 1'b1;
          end else if (b != OPT_PAD) begin
            n.code  = b;
            n.phase = PH_LEN;
          end
        end
      endcase
    end
    n.la = {incoming, s.la[3], s.la[2], s.la[1]};
    return n;
  endfunction

  logic [31:0]            expected_xid;
  logic [31:0]            packet_xid;
  logic [31:0]            your_address;
  walk_t                  ws;
  walk_t                  ws_next;
  walk_t                  step_out;
  walk_t                  cleared;
  logic                   draining;
  logic [DRAIN_W-1:0]     drain_k;
  logic [DRAIN_STEPS-1:0] drain_act;
  logic [DRAIN_STEPS-1:0] drain_end;

  logic       xid_match;
  logic       need_drain;
  logic       out_free;
  logic       early_finish;
  logic       drain_finish;
  logic       drain_advance;
  logic       load;
  logic [1:0] res_verdict;
  logic [RES_W-3:0] res_fields;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_xid <= XID_RESET;
    end else if (cfg_valid) begin
      expected_xid <= cfg_data;
    end
  end

  assign xid_match  = packet_xid == expected_xid;
  // only a full-length message with a matching id has options worth draining
  assign need_drain = head.last && !head.cls.short_msg && xid_match;
  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign pop        = !empty && !draining && (!head.last || need_drain || out_free);

  assign early_finish  = pop && head.last && !need_drain;
  assign drain_finish  = draining && (drain_k == DRAIN_LAST) && out_free;
  assign drain_advance = draining && (drain_k != DRAIN_LAST);
  assign load          = early_finish || drain_finish;

  always_comb begin
    if (draining) begin
      step_out = walk_step(ws, 8'd0, drain_act[drain_k], drain_end[drain_k]);
    end else begin
      step_out = walk_step(ws, head.data, head.cls.walk_on && xid_match, head.cls.area_end);
    end
  end

  always_comb begin
    cleared       = '0;
    cleared.phase = PH_CODE;
    cleared.sid   = draining ? step_out.sid : ws.sid;
  end

  always_comb begin
    ws_next = ws;
    if (load) begin
      ws_next = cleared;
    end else if (pop || drain_advance) begin
      ws_next = step_out;
    end
  end

  always_comb begin
    res_verdict = VERDICT_MISMATCH;
    res_fields  = '0;
    if (draining) begin
      if (step_out.kind == MSG_OFFER) begin
        res_verdict = VERDICT_OFFER;
        res_fields  = {step_out.sid,
                       (step_out.dns != '0) ? step_out.dns : DEF_DNS,
                       step_out.router,
                       (step_out.mask != '0) ? step_out.mask : DEF_MASK,
                       your_address};
      end else begin
        res_verdict = VERDICT_NOT_OFFER;
      end
    end else if (head.cls.short_msg) begin
      res_verdict = VERDICT_SHORT;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.cls.xid_we) begin
      packet_xid[{head.cls.xid_lane, 3'b000} +: 8] <= head.data;
    end
    if (pop && head.cls.yi_we) begin
      your_address[{head.cls.yi_lane, 3'b000} +: 8] <= head.data;
    end
    if (pop && need_drain) begin
      drain_act <= head.cls.drain_act;
      drain_end <= head.cls.drain_end;
    end
    if (load) begin
      m_axis_tdata <= {(OUT_W - RES_W)'(0), res_fields, res_verdict};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ws            <= '0;
      draining      <= 1'b0;
      drain_k       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      ws <= ws_next;
      if (pop && need_drain) begin
        draining <= 1'b1;
        drain_k  <= '0;
      end else if (drain_finish) begin
        draining <= 1'b0;
      end else if (drain_advance) begin
        drain_k <= drain_k + DRAIN_W'(1);
      end
      if (load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  a_hold_during_drain: assert property (@(posedge clk) disable iff (rst) draining |-> !pop)
    else $error("queue popped during drain");

  a_drain_runs_out: assert property (@(posedge clk) disable iff (rst)
    (draining && drain_k != DRAIN_LAST) |=> draining)
    else $error("drain ended early");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[1:0] != VERDICT_OFFER) |-> (m_axis_tdata[OUT_W-1:2] == '0))
    else $error("rejected message carries nonzero fields");

endmodule

>>> tb/dhcp_verdict_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhcp_verdict_checker: verdict predictor and comparator for the offer parser
// Watches the cfg, byte and verdict channels, tracks the message and option
// walk on its own, and compares each verdict field by field with the oldest
// prediction. Failures and outstanding predictions go to the testbench top.
// ----------------------------------------------------------------------------
module dhcp_verdict_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [31:0]               cfg_data,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,
  input  logic                      s_axis_tlast,
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic [dop_pkg::OUT_W-1:0] m_axis_tdata,
  output int unsigned               fail_count,
  output int unsigned               verdicts_due,
  output int unsigned               results_checked,
  output int unsigned               offers_checked
);
  import dop_pkg::*;

  typedef enum logic [1:0] {WALK_CODE, WALK_LEN, WALK_SKIP} walk_phase_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [31:0] offer_addr;
    logic [31:0] netmask;
    logic [31:0] gateway;
    logic [31:0] dns_server;
    logic [31:0] server_id;
  } offer_verdict_t;

  offer_verdict_t pending_verdicts[$];

  logic [31:0]        want_xid;
  logic [OFFSET_W-1:0] pos;
  walk_phase_t        phase;
  logic [7:0]         skip_left;
  logic [7:0]         cur_code;
  logic [7:0]         ahead[4];
  logic [31:0]        rx_xid;
  logic [31:0]        yi_addr;
  logic [7:0]         kind_byte;
  logic [31:0]        mask_v;
  logic [31:0]        router_v;
  logic [31:0]        dns_v;
  logic [31:0]        srv_id;
  logic               opts_done;

  task automatic forget_message();
    pos       = '0;
    phase     = WALK_CODE;
    skip_left = '0;
    cur_code  = '0;
    ahead     = '{default: 8'h00};
    rx_xid    = '0;
    yi_addr   = '0;
    kind_byte = '0;
    mask_v    = '0;
    router_v  = '0;
    dns_v     = '0;
    opts_done = 1'b0;
  endtask

  // one step of the option walk at message position w; the value bytes of
  // the option sit in the look-ahead window plus the incoming byte
  task automatic walk_option(input bit in_view, input int w, input logic [7:0] incoming);
    logic [7:0]  b;
    logic [31:0] v;
    b = ahead[0];
    v = {ahead[1], ahead[2], ahead[3], incoming};
    if (in_view && !opts_done && w >= OPT_START && rx_xid == want_xid) begin
      case (phase)
        WALK_LEN: begin
          case (cur_code)
            OPT_MSG_TYPE: kind_byte = ahead[1];
            OPT_SERVER:   srv_id    = v;
            OPT_MASK:     mask_v    = v;
            OPT_ROUTER:   router_v  = v;
            OPT_DNS:      dns_v     = v;
            default: ;
          endcase
          skip_left = b;
          phase     = (b != 8'd0) ? WALK_SKIP : WALK_CODE;
        end
        WALK_SKIP: begin
          if (skip_left <= 8'd1) begin
            skip_left = '0;
            phase     = WALK_CODE;
          end else begin
            skip_left = skip_left - 8'd1;
          end
        end
        default: begin
          if (w - OPT_START >= OPT_AREA || b == OPT_END) begin
            opts_done = 1'b1;
          end else if (b != OPT_PAD) begin
            cur_code = b;
            phase    = WALK_LEN;
          end
        end
      endcase
    end
    ahead[0] = ahead[1];
    ahead[1] = ahead[2];
    ahead[2] = ahead[3];
    ahead[3] = incoming;
  endtask

  task automatic take_byte(input logic [7:0] b, input logic last);
    int             q;
    int             cnt;
    int             k;
    offer_verdict_t r;
    q = int'(pos);
    if (q >= XID_FIRST && q < XID_FIRST + 4)
      rx_xid |= 32'(b) << (8 * (q - XID_FIRST));
    if (q >= YI_FIRST && q < YI_FIRST + 4)
      yi_addr |= 32'(b) << (8 * (YI_FIRST + 3 - q));
    walk_option(q >= WALK_LAG, q - WALK_LAG, b);
    cnt = (q < int'(OFFSET_MAX)) ? q + 1 : int'(OFFSET_MAX);
    pos = cnt[OFFSET_W-1:0];
    if (last) begin
      // run out the look-ahead with zeros past the final byte
      for (k = 0; k < DRAIN_STEPS; k++)
        walk_option(q + k >= WALK_LAG - 1, q + k - (WALK_LAG - 1), 8'h00);
      r = '0;
      if (cnt < MIN_LEN) begin
        r.verdict = VERDICT_SHORT;
      end else if (rx_xid != want_xid) begin
        r.verdict = VERDICT_MISMATCH;
      end else if (kind_byte != MSG_OFFER) begin
        r.verdict = VERDICT_NOT_OFFER;
      end else begin
        r.verdict    = VERDICT_OFFER;
        r.offer_addr = yi_addr;
        r.netmask    = (mask_v != '0) ? mask_v : DEF_MASK;
        r.gateway    = router_v;
        r.dns_server = (dns_v != '0) ? dns_v : DEF_DNS;
        r.server_id  = srv_id;
      end
      pending_verdicts.push_back(r);
      forget_message();
    end
  endtask

  task automatic check_verdict();
    offer_verdict_t want;
    offer_verdict_t got;
    got.verdict    = m_axis_tdata[1:0];
    got.offer_addr = m_axis_tdata[2 +: 32];
    got.netmask    = m_axis_tdata[34 +: 32];
    got.gateway    = m_axis_tdata[66 +: 32];
    got.dns_server = m_axis_tdata[98 +: 32];
    got.server_id  = m_axis_tdata[130 +: 32];
    results_checked++;
    if (pending_verdicts.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: verdict %0d arrived with none pending", $time, got.verdict);
    end else begin
      want = pending_verdicts.pop_front();
      if (want.verdict == VERDICT_OFFER)
        offers_checked++;
      if (got !== want) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: verdict mismatch (exp / got)", $time);
          $display("  verdict %0d / %0d  ip %h / %h  mask %h / %h", want.verdict,
                   got.verdict, want.offer_addr, got.offer_addr, want.netmask, got.netmask);
          $display("  gw %h / %h  dns %h / %h  server %h / %h", want.gateway, got.gateway,
                   want.dns_server, got.dns_server, want.server_id, got.server_id);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      want_xid = XID_RESET;
      srv_id   = '0;
      forget_message();
      pending_verdicts.delete();
      fail_count      = 0;
      results_checked = 0;
      offers_checked  = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        check_verdict();
      if (cfg_valid && cfg_ready)
        want_xid = cfg_data;
      if (s_axis_tvalid && s_axis_tready)
        take_byte(s_axis_tdata, s_axis_tlast);
    end
    verdicts_due = pending_verdicts.size();
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the dhcp offer parser
// Streams directed and random DHCP messages (short, id mismatch, malformed,
// truncated and well-formed offers) under several expected ids, with random
// stalls on both sides; a checker module predicts and compares each verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import dop_pkg::*;

  localparam int IDLE_PCT    = 18;
  localparam int HOLD_CYCLES = 300;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [31:0]        cfg_data;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata;
  logic               s_axis_tlast;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [OUT_W-1:0]   m_axis_tdata;

  int unsigned fail_count;
  int unsigned verdicts_due;
  int unsigned results_checked;
  int unsigned offers_checked;

  logic [7:0]  frame[$];
  logic [31:0] cur_xid;
  int          bytes_sent  = 0;
  int          frames_sent = 0;
  int          holds_asked = 0;
  int          holds_taken = 0;
  bit          quiet = 1'b0;

  dhcp_offer_option_parser u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  dhcp_verdict_checker u_chk (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tlast    (s_axis_tlast),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .fail_count      (fail_count),
    .verdicts_due    (verdicts_due),
    .results_checked (results_checked),
    .offers_checked  (offers_checked)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #4_000_000;
    $display("run timed out with %0d verdicts pending", verdicts_due);
    $display("tb: failure");
    $finish;
  end

  // verdict side: random stalls, plus long hold-offs on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_taken < holds_asked) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_taken++;
      end else begin
        m_axis_tready = quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tlast  = last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame[k])
      push_byte(frame[k], k == frame.size() - 1);
    frames_sent++;
  endtask

  // only between messages: all verdicts back, then a margin of idle clocks
  task automatic write_xid(input logic [31:0] v);
    while (verdicts_due != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    cur_xid   = v;
  endtask

  task automatic start_frame(input logic [31:0] xid, input logic [31:0] yi);
    int k;
    frame.delete();
    repeat (OPT_START) frame.push_back(8'($urandom));
    for (k = 0; k < 4; k++) begin
      frame[XID_FIRST + k] = xid[8*k +: 8];
      frame[YI_FIRST + k]  = yi[31 - 8*k -: 8];
    end
  endtask

  task automatic put_option(input logic [7:0] code, input logic [7:0] len,
                            input logic [31:0] value);
    int k;
    frame.push_back(code);
    frame.push_back(len);
    for (k = 0; k < len; k++)
      frame.push_back((k < 4) ? value[31 - 8*k -: 8] : 8'($urandom));
  endtask

  task automatic short_frame(input int n);
    frame.delete();
    repeat (n) frame.push_back(8'($urandom));
    send_frame();
  endtask

  task automatic random_frame();
    int          pick;
    int          c;
    int          k;
    int          n;
    logic [31:0] v;
    logic [7:0]  len;
    logic [7:0]  kind;
    pick = $urandom_range(99);
    if (pick < 25) begin
      n = ($urandom_range(99) < 80) ? $urandom_range(1, 12) : $urandom_range(13, 239);
      short_frame(n);
    end else begin
      if (pick < 32) begin
        // garbage header and options
        start_frame($urandom_range(1) ? cur_xid : $urandom, $urandom);
        repeat ($urandom_range(0, 80)) frame.push_back(8'($urandom));
      end else begin
        start_frame((pick < 42) ? cur_xid ^ (32'h1 << $urandom_range(31)) : cur_xid,
                    $urandom);
        if ($urandom_range(99) < 70) begin
          kind = ($urandom_range(99) < 80) ? MSG_OFFER : 8'($urandom);
          put_option(OPT_MSG_TYPE, 8'd1, {kind, 24'($urandom)});
        end
        repeat ($urandom_range(0, 7)) begin
          c = $urandom_range(0, 7);
          v = ($urandom_range(99) < 25) ? 32'h0 : $urandom;
          k = $urandom_range(99);
          len = (k < 70) ? 8'd4 : ((k < 95) ? 8'($urandom_range(0, 8))
                                            : 8'($urandom_range(9, 40)));
          kind = ($urandom_range(99) < 75) ? MSG_OFFER : 8'($urandom);
          case (c)
            0: put_option(OPT_MSG_TYPE, ($urandom_range(3) == 0) ? 8'($urandom_range(0, 4))
                                                                 : 8'd1,
                          {kind, 24'($urandom)});
            1: put_option(OPT_SERVER, len, v);
            2: put_option(OPT_MASK, len, v);
            3: put_option(OPT_ROUTER, len, v);
            4: put_option(OPT_DNS, len, v);
            5: frame.push_back(OPT_PAD);
            default: put_option(8'($urandom_range(2, 254)), len, v);
          endcase
        end
        if ($urandom_range(99) < 85)
          frame.push_back(OPT_END);
        if ($urandom_range(1))
          repeat ($urandom_range(1, 8)) frame.push_back(8'($urandom));
        // cut the tail so option values run past the final byte
        if ($urandom_range(99) < 15)
          repeat ($urandom_range(1, 6)) void'(frame.pop_back());
      end
      send_frame();
    end
  endtask

  initial begin
    int phase_no;
    int wait_cnt;
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cur_xid       = XID_RESET;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // single byte, and one byte short of the minimum
    frame.delete();
    frame.push_back(8'hFF);
    send_frame();
    start_frame(cur_xid, $urandom);
    void'(frame.pop_back());
    send_frame();

    // minimum length, no options at all
    start_frame(cur_xid, $urandom);
    send_frame();

    // full offer, with a zero-length option in the list
    start_frame(cur_xid, 32'h0000_0000);
    put_option(OPT_MSG_TYPE, 8'd1, {MSG_OFFER, 24'h0});
    put_option(OPT_SERVER, 8'd4, 32'hC0A8_0101);
    put_option(OPT_MASK, 8'd4, 32'hFFFF_FF00);
    put_option(8'd12, 8'd0, 32'h0);
    put_option(OPT_ROUTER, 8'd4, 32'hC0A8_0001);
    put_option(OPT_DNS, 8'd4, 32'h0101_0101);
    frame.push_back(OPT_END);
    send_frame();

    // zero mask and dns fall back, no router, server id carried over
    start_frame(cur_xid, 32'hFFFF_FFFF);
    frame.push_back(OPT_PAD);
    put_option(OPT_MSG_TYPE, 8'd1, {MSG_OFFER, 24'hFFFFFF});
    put_option(OPT_MASK, 8'd4, 32'h0);
    put_option(OPT_DNS, 8'd4, 32'h0);
    frame.push_back(OPT_END);
    send_frame();

    // id mismatch on an otherwise good offer
    start_frame(cur_xid ^ 32'h8000_0001, $urandom);
    put_option(OPT_MSG_TYPE, 8'd1, {MSG_OFFER, 24'h0});
    put_option(OPT_SERVER, 8'd4, 32'hDEAD_BEEF);
    frame.push_back(OPT_END);
    send_frame();

    // only the first message type byte counts
    start_frame(cur_xid, $urandom);
    put_option(OPT_MSG_TYPE, 8'd3, 32'h0502_0202);
    frame.push_back(OPT_END);
    send_frame();
    start_frame(cur_xid, $urandom);
    put_option(OPT_MSG_TYPE, 8'd3, 32'h0205_0505);
    put_option(8'd43, 8'd255, $urandom);
    put_option(OPT_SERVER, 8'd2, 32'h0A0B_0C0D);
    frame.push_back(OPT_END);
    send_frame();

    // values read past the final byte come in as zero
    start_frame(cur_xid, $urandom);
    put_option(OPT_MSG_TYPE, 8'd1, {MSG_OFFER, 24'h0});
    put_option(OPT_ROUTER, 8'd4, $urandom);
    frame.push_back(OPT_SERVER);
    frame.push_back(8'd4);
    frame.push_back(8'hAB);
    send_frame();
    start_frame(cur_xid, $urandom);
    put_option(OPT_MSG_TYPE, 8'd1, {MSG_OFFER, 24'h0});
    frame.push_back(OPT_DNS);
    send_frame();

    // option code at the last position of the area, then one past it
    start_frame(cur_xid, $urandom);
    repeat (OPT_AREA - 1) frame.push_back(OPT_PAD);
    put_option(OPT_MSG_TYPE, 8'd1, {MSG_OFFER, 24'h0});
    frame.push_back(OPT_END);
    send_frame();
    start_frame(cur_xid, $urandom);
    repeat (OPT_AREA) frame.push_back(OPT_PAD);
    put_option(OPT_MSG_TYPE, 8'd1, {MSG_OFFER, 24'h0});
    frame.push_back(OPT_END);
    send_frame();

    // overlong message, byte count saturates
    start_frame(cur_xid, $urandom);
    put_option(OPT_MSG_TYPE, 8'd1, {MSG_OFFER, 24'h0});
    put_option(OPT_SERVER, 8'd4, $urandom);
    frame.push_back(OPT_END);
    while (frame.size() < 2100) frame.push_back(8'($urandom));
    send_frame();

    phase_no = 0;
    while (phase_no < 4) begin
      if (phase_no == 0)
        write_xid(32'h0000_0000);
      else if (phase_no == 1)
        write_xid(32'hFFFF_FFFF);
      else if (phase_no == 2)
        write_xid(XID_RESET);
      else
        write_xid($urandom);
      quiet = (phase_no == 3);
      if (phase_no == 1) begin
        // verdict side holds off while short messages keep coming
        holds_asked++;
        repeat (40) short_frame($urandom_range(1, 3));
      end
      repeat (3) random_frame();
      quiet = 1'b0;
      phase_no++;
    end

    s_axis_tvalid = 1'b0;
    wait_cnt = 0;
    while (verdicts_due != 0 && wait_cnt < 5000) begin
      @(negedge clk);
      wait_cnt++;
    end
    repeat (20) @(negedge clk);
    if (verdicts_due != 0)
      $display("%0d predicted verdicts never arrived", verdicts_due);
    $display("summary: %0d messages, %0d bytes over %0d expected-id settings",
             frames_sent, bytes_sent, phase_no + 1);
    $display("summary: %0d verdicts compared, %0d of them accepted offers",
             results_checked, offers_checked);
    if (fail_count == 0 && verdicts_due == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
